>>> hdl/cta_pkg.sv
package cta_pkg;

  localparam int FRAC_BITS  = 8;
  localparam int WARMUP     = 4;

  localparam int T_W        = 12;
  localparam int H_W        = 10;
  localparam int CNT_W      = 8;

  localparam int AVG_T_W    = T_W + FRAC_BITS;
  localparam int AVG_H_W    = H_W + FRAC_BITS;

  // The divider lane takes a signed difference one bit wider than the
  // widest average, and a divisor that can reach 2^CNT_W.
  localparam int DIV_W      = AVG_T_W + 1;
  localparam int DVSR_W     = CNT_W + 1;
  localparam int DIV_CNT_W  = $clog2(DIV_W);

  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 32;
  localparam int APB_AW     = 3;
  localparam int APB_DW     = 32;

  localparam logic REG_TEMP_THR = 1'b0;
  localparam logic REG_HUM_THR  = 1'b1;

  localparam logic signed [T_W-1:0] TEMP_THR_RST = 12'sd300;
  localparam logic        [H_W-1:0] HUM_THR_RST  = 10'd700;

endpackage

>>> hdl/climate_threshold_and_running_average.sv
// Flow: a reading taken during warm-up (count at most WARMUP) goes from ST_IDLE straight
// to ST_EMIT; a later reading first waits in ST_DIVIDE for the two bit-serial divider
// lanes that run side by side. The result is then registered onto the output.
// A new reading is taken only in ST_IDLE, so none is accepted until the last result is
// loaded, which waits while the result side stalls; a failed reading leaves it idle.
// Reset (rst_ni low, asynchronous): averages, count and vent latch go to zero,
// thresholds to 300 and 700, and no result is pending.
module climate_threshold_and_running_average
  import cta_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_AW-1:0]     paddr,
  input  logic [APB_DW-1:0]     pwdata,
  output logic [APB_DW-1:0]     prdata,
  output logic                  pready,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // [11:0] temperature_x10, [21:12] humidity_x10, [22] co2_vent_open, [23] clear_after
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // [0] reading_ok
  input  logic [0:0]            s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // [0] alarm_on, [1] vent_open, [2] vent_latched, [14:3] avg_temperature_x10,
  // [24:15] avg_humidity_x10, [31:25] zero
  output logic [OUT_DATA_W-1:0] m_axis_tdata
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_EMIT
  } state_e;

  state_e                      state_q;
  logic signed [T_W-1:0]       temp_thr_q;
  logic        [H_W-1:0]       hum_thr_q;
  logic signed [AVG_T_W-1:0]   avg_t_q;
  logic        [AVG_H_W-1:0]   avg_h_q;
  logic        [CNT_W-1:0]     count_q;
  logic                        latch_q;
  logic                        alarm_q;
  logic                        vent_q;
  logic                        clear_q;
  logic                        m_valid_q;
  logic [OUT_DATA_W-1:0]       m_data_q;

  logic signed [T_W-1:0]       temp_in;
  logic        [H_W-1:0]       hum_in;
  logic                        co2_in;
  logic                        clear_in;
  logic                        ok_in;
  logic                        accept;
  logic                        emit;
  logic                        warm;
  logic                        alarm;
  logic                        vent;
  logic signed [AVG_T_W-1:0]   scaled_t;
  logic        [AVG_H_W-1:0]   scaled_h;
  logic signed [DIV_W-1:0]     diff_t;
  logic signed [DIV_W-1:0]     diff_h;
  logic        [DVSR_W-1:0]    divisor;
  logic                        div_start;
  logic                        done_t;
  logic                        done_h;
  logic signed [DIV_W-1:0]     quot_t;
  logic signed [DIV_W-1:0]     quot_h;
  logic signed [DIV_W-1:0]     sum_t;
  logic signed [DIV_W-1:0]     sum_h;
  logic signed [T_W-1:0]       avg_t_out;
  logic        [H_W-1:0]       avg_h_out;
  logic                        t_round;
  logic                        cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      temp_thr_q <= TEMP_THR_RST;
      hum_thr_q  <= HUM_THR_RST;
    end else if (cfg_write) begin
      case (paddr[2])
        REG_TEMP_THR: temp_thr_q <= pwdata[T_W-1:0];
        REG_HUM_THR:  hum_thr_q  <= pwdata[H_W-1:0];
        default:      ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_TEMP_THR: prdata = APB_DW'(temp_thr_q);
      REG_HUM_THR:  prdata = APB_DW'(hum_thr_q);
      default:      prdata = '0;
    endcase
  end

  assign temp_in  = s_axis_tdata[T_W-1:0];
  assign hum_in   = s_axis_tdata[T_W+H_W-1:T_W];
  assign co2_in   = s_axis_tdata[T_W+H_W];
  assign clear_in = s_axis_tdata[T_W+H_W+1];
  assign ok_in    = s_axis_tuser[0];

  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign emit          = (state_q == ST_EMIT) && (!m_valid_q || m_axis_tready);

  assign warm  = count_q <= CNT_W'(WARMUP);
  assign alarm = temp_in > temp_thr_q;
  assign vent  = (hum_in > hum_thr_q) && !co2_in;

  assign scaled_t = {temp_in, {FRAC_BITS{1'b0}}};
  assign scaled_h = {hum_in, {FRAC_BITS{1'b0}}};
  assign diff_t   = DIV_W'(scaled_t) - DIV_W'(avg_t_q);
  assign diff_h   = $signed(DIV_W'(scaled_h)) - $signed(DIV_W'(avg_h_q));
  assign divisor  = DVSR_W'(count_q) + DVSR_W'(1);
  assign div_start = accept && ok_in && !warm;

  cta_serial_div u_div_t (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (diff_t),
    .divisor_i  (divisor),
    .done_o     (done_t),
    .quotient_o (quot_t)
  );

  cta_serial_div u_div_h (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (diff_h),
    .divisor_i  (divisor),
    .done_o     (done_h),
    .quotient_o (quot_h)
  );

  assign sum_t = DIV_W'(avg_t_q) + quot_t;
  assign sum_h = $signed(DIV_W'(avg_h_q)) + quot_h;

  // The reported temperature truncates toward zero, so a negative average
  // with a nonzero fraction rounds up by one.
  assign t_round   = avg_t_q[AVG_T_W-1] && (avg_t_q[FRAC_BITS-1:0] != '0);
  assign avg_t_out = avg_t_q[AVG_T_W-1:FRAC_BITS] + T_W'(t_round);
  assign avg_h_out = avg_h_q[AVG_H_W-1:FRAC_BITS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      avg_t_q   <= '0;
      avg_h_q   <= '0;
      count_q   <= '0;
      latch_q   <= 1'b0;
      alarm_q   <= 1'b0;
      vent_q    <= 1'b0;
      clear_q   <= 1'b0;
      m_valid_q <= 1'b0;
      m_data_q  <= '0;
    end else begin
      if (emit) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            if (ok_in) begin
              alarm_q <= alarm;
              vent_q  <= vent;
              clear_q <= clear_in;
              if (vent) begin
                latch_q <= 1'b1;
              end
              if (warm) begin
                avg_t_q <= scaled_t;
                avg_h_q <= scaled_h;
                count_q <= count_q + CNT_W'(1);
                state_q <= ST_EMIT;
              end else begin
                state_q <= ST_DIVIDE;
              end
            end else if (clear_in) begin
              avg_t_q <= '0;
              avg_h_q <= '0;
              count_q <= '0;
            end
          end
        end
        ST_DIVIDE: begin
          if (done_t && done_h) begin
            avg_t_q <= sum_t[AVG_T_W-1:0];
            avg_h_q <= sum_h[AVG_H_W-1:0];
            count_q <= count_q + CNT_W'(1);
            state_q <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (emit) begin
            m_data_q  <= OUT_DATA_W'({avg_h_out, avg_t_out, latch_q, vent_q, alarm_q});
            if (clear_q) begin
              avg_t_q <= '0;
              avg_h_q <= '0;
              count_q <= '0;
            end
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

endmodule

>>> hdl/cta_serial_div.sv
module cta_serial_div
  import cta_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic signed [DIV_W-1:0]  dividend_i,
  input  logic        [DVSR_W-1:0] divisor_i,
  output logic                     done_o,
  output logic signed [DIV_W-1:0]  quotient_o
);

  logic                 busy_q;
  logic                 done_q;
  logic                 neg_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [DIV_W-1:0]     shreg_q;
  logic [DVSR_W-1:0]    rem_q;
  logic [DVSR_W-1:0]    dvsr_q;

  logic [DIV_W-1:0]     magnitude;
  logic [DVSR_W:0]      trial;
  logic                 fits;
  logic [DVSR_W:0]      trial_diff;

  assign magnitude  = dividend_i[DIV_W-1] ? DIV_W'(-dividend_i) : DIV_W'(dividend_i);
  assign trial      = {rem_q, shreg_q[DIV_W-1]};
  assign fits       = trial >= {1'b0, dvsr_q};
  assign trial_diff = trial - {1'b0, dvsr_q};

  // Restoring division: the dividend shifts out at the top of shreg_q while
  // quotient bits shift in at the bottom, one bit per cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
      neg_q   <= 1'b0;
      cnt_q   <= '0;
      shreg_q <= '0;
      rem_q   <= '0;
      dvsr_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q  <= 1'b1;
        neg_q   <= dividend_i[DIV_W-1];
        cnt_q   <= '0;
        shreg_q <= magnitude;
        rem_q   <= '0;
        dvsr_q  <= divisor_i;
      end else if (busy_q) begin
        shreg_q <= {shreg_q[DIV_W-2:0], fits};
        rem_q   <= fits ? trial_diff[DVSR_W-1:0] : trial[DVSR_W-1:0];
        cnt_q   <= cnt_q + DIV_CNT_W'(1);
        if (cnt_q == DIV_CNT_W'(DIV_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o     = done_q;
  assign quotient_o = neg_q ? DIV_W'(-shreg_q) : DIV_W'(shreg_q);

endmodule

>>> hdl/cta_checker.sv
module cta_checker
  import cta_pkg::*;
(
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  pready,
  input logic                  s_axis_tready,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [OUT_DATA_W-1:0] m_axis_tdata
);

  // A beat that waits must keep its data.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result beat changed while stalled");

  // A new result is loaded only while the input side is closed.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> !$past(s_axis_tready))
    else $error("result appeared without a reading in flight");

  // The vent latch is sticky, so an open vent always shows it set.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[1] |-> m_axis_tdata[2])
    else $error("vent open without latch");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[OUT_DATA_W-1:25] == '0)
    else $error("padding bits of result are not zero");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pready)
    else $error("pready dropped");

endmodule

bind climate_threshold_and_running_average cta_checker u_cta_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .pready        (pready),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
